[rtl/core/urxf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urxf_pkg
// Shared types and constants for the 8N1 serial receiver with receive FIFO.
// ----------------------------------------------------------------------------
package urxf_pkg;

  // FIFO ring geometry: DEPTH slots, DEPTH-1 usable bytes
  localparam int DEPTH    = 64;
  localparam int PTR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W  = 6;
  localparam int CNT_W    = (PTR_W > COUNT_W) ? PTR_W : COUNT_W;
  localparam int DATA_W   = 8;
  localparam int BITCNT_W = $clog2(DATA_W);

  typedef logic [PTR_W-1:0] ptr_t;

  // Input item codes
  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_FLUSH = 2'd3
  } action_e;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INVERT_LINE = 2'd0,
    CFG_ENABLED     = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    action_e action;
    logic    line_level;
  } in_item_t;

  typedef struct packed {
    logic               read_valid;
    logic [DATA_W-1:0]  read_data;
    logic               byte_stored;
    logic               overflow;
    logic [COUNT_W-1:0] fifo_count;
  } out_item_t;

  // Completed frame handed from the frame receiver to the FIFO
  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } push_t;

  // Per-transaction FIFO status, read data travels separately
  typedef struct packed {
    logic               read_valid;
    logic               byte_stored;
    logic               overflow;
    logic [COUNT_W-1:0] fifo_count;
  } fifo_res_t;

  // Frame receiver states, one-hot
  typedef enum logic [3:0] {
    FR_IDLE  = 4'b0001,
    FR_START = 4'b0010,
    FR_DATA  = 4'b0100,
    FR_STOP  = 4'b1000
  } frame_state_e;

  function automatic ptr_t ring_next(input ptr_t p);
    ring_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + ptr_t'(1);
  endfunction

  function automatic logic [COUNT_W-1:0] ring_count(input ptr_t w, input ptr_t r);
    logic [CNT_W-1:0] we;
    logic [CNT_W-1:0] re;
    logic [CNT_W-1:0] c;
    we = CNT_W'(w);
    re = CNT_W'(r);
    if (we >= re) c = we - re;
    else          c = we + CNT_W'(DEPTH) - re;
    ring_count = c[COUNT_W-1:0];
  endfunction

endpackage

[rtl/core/urxf_frame.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urxf_frame
// 8N1 frame receiver: start re-check, eight data bits LSB first, stop check.
// ----------------------------------------------------------------------------
module urxf_frame import urxf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     accept_i,
  input  in_item_t item_i,
  input  logic     invert_i,
  output push_t    push_o
);

  frame_state_e        state_q, state_d;
  logic                phase_q, phase_d;
  logic [BITCNT_W-1:0] bitcnt_q, bitcnt_d;
  logic [DATA_W-1:0]   shift_q, shift_d;
  logic                level;
  logic                sample;

  assign level = item_i.line_level ^ invert_i;

  // A tick samples the line when it sets the phase bit
  assign sample = accept_i && (item_i.action == ACT_TICK) &&
                  (state_q != FR_IDLE) && !phase_q;

  // Next-state logic
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    bitcnt_d    = bitcnt_q;
    shift_d     = shift_q;
    push_o      = '{valid: 1'b0, data: shift_q};
    if (accept_i && item_i.action == ACT_START && state_q == FR_IDLE) begin
      phase_d = 1'b0;
      state_d = FR_START;
    end
    if (accept_i && item_i.action == ACT_TICK && state_q != FR_IDLE) begin
      phase_d = !phase_q;
    end
    if (sample) begin
      unique case (state_q)
        FR_IDLE: begin
        end
        FR_START: begin
          if (!level) begin
            state_d  = FR_DATA;
            bitcnt_d = '0;
          end else begin
            state_d = FR_IDLE;
          end
        end
        FR_DATA: begin
          shift_d  = {level, shift_q[DATA_W-1:1]};
          bitcnt_d = bitcnt_q + BITCNT_W'(1);
          if (bitcnt_q == BITCNT_W'(DATA_W - 1)) state_d = FR_STOP;
        end
        FR_STOP: begin
          push_o.valid = level;
          state_d      = FR_IDLE;
        end
        default: state_d = FR_IDLE;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FR_IDLE;
      phase_q  <= 1'b0;
      bitcnt_q <= '0;
      shift_q  <= '0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      bitcnt_q <= bitcnt_d;
      shift_q  <= shift_d;
    end
  end

endmodule

[rtl/core/urxf_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urxf_fifo
// Receive ring of DEPTH slots with push, pop, flush and a registered read.
// ----------------------------------------------------------------------------
module urxf_fifo import urxf_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  action_e           action_i,
  input  logic              enabled_i,
  input  push_t             push_i,
  output fifo_res_t         res_o,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;
  ptr_t              wptr_q, wptr_d;
  ptr_t              rptr_q, rptr_d;
  ptr_t              wnext;
  logic              full;
  logic              do_push;
  logic              do_pop;

  assign wnext   = ring_next(wptr_q);
  assign full    = (wnext == rptr_q);
  assign do_push = push_i.valid && !full;
  assign do_pop  = accept_i && (action_i == ACT_READ) && enabled_i && (rptr_q != wptr_q);

  // Pointer update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    if (do_push) wptr_d = wnext;
    if (do_pop)  rptr_d = ring_next(rptr_q);
    if (accept_i && action_i == ACT_FLUSH) begin
      wptr_d = '0;
      rptr_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
    end
  end

  // Storage write port
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= push_i.data;
  end

  // Storage read port, data registered
  always_ff @(posedge clk_i) begin
    if (do_pop) rdata_q <= mem_q[rptr_q];
  end

  assign rdata_o            = rdata_q;
  assign res_o.read_valid   = do_pop;
  assign res_o.byte_stored  = do_push;
  assign res_o.overflow     = push_i.valid && full;
  assign res_o.fifo_count   = ring_count(wptr_d, rptr_d);

endmodule

[rtl/core/uart_receiver_with_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uart_receiver_with_fifo
// 8N1 serial receiver stepped by events, with a receive FIFO.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one event per transaction:
// start edge, half-bit tick with the sampled line level, read pop or flush.
// Every accepted transaction yields exactly one result on the output channel
// (out_valid_o/out_ready_i): popped byte, stored/overflow strobes and the
// FIFO fill level after the event.
// The result is registered: it sits in the output register on the cycle
// after acceptance. Throughput is one transaction per cycle unless the output
// stalls; the output register and FIFO read port form the single stage that sets it.
// While the output side stalls, in_ready_o drops and the pending result is
// held; it rises again in the same cycle the result is taken.
// The configuration channel (cfg_valid_i/cfg_ready_o) is always ready;
// index 0 is line inversion, index 1 is receiver enable, other indexes are
// ignored. Write it only while no transaction is in flight.
// Reset clears the receiver to idle, empties the FIFO and clears both
// configuration bits. FIFO storage needs no clearing pass.
// ----------------------------------------------------------------------------
module uart_receiver_with_fifo import urxf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_item_t            out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic                 cfg_data_i
);

  logic              accept;
  logic              invert_q;
  logic              enabled_q;
  logic              out_valid_q;
  fifo_res_t         res_q;
  fifo_res_t         res;
  push_t             push;
  logic [DATA_W-1:0] rdata;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q  <= 1'b0;
      enabled_q <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_INVERT_LINE: invert_q  <= cfg_data_i;
        CFG_ENABLED:     enabled_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  urxf_frame u_frame (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_item_i),
    .invert_i (invert_q),
    .push_o   (push)
  );

  urxf_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .action_i  (in_item_i.action),
    .enabled_i (enabled_q),
    .push_i    (push),
    .res_o     (res),
    .rdata_o   (rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) res_q <= res;
  end

  assign out_valid_o            = out_valid_q;
  assign out_item_o.read_valid  = res_q.read_valid;
  assign out_item_o.read_data   = res_q.read_valid ? rdata : '0;
  assign out_item_o.byte_stored = res_q.byte_stored;
  assign out_item_o.overflow    = res_q.overflow;
  assign out_item_o.fifo_count  = res_q.fifo_count;

endmodule

[rtl/core/urxf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urxf_checker
// Port-level checks for the receiver, attached to the top level by bind.
// ----------------------------------------------------------------------------
module urxf_checker import urxf_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input in_item_t             in_item_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input out_item_t            out_item_o
);

  // No result is shown once reset has been seen
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // A taken result always frees the input side in the same cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_ready_i |-> in_ready_o)
    else $error("input stalled while output is being taken");

  // A result without a popped byte carries zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.read_valid) |-> (out_item_o.read_data == '0))
    else $error("read data not zero without a pop");

  // A frame is either stored or dropped, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_item_o.byte_stored && out_item_o.overflow))
    else $error("stored and overflow in one result");

  // A flush shows an empty FIFO in the next result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_item_i.action == ACT_FLUSH) |=>
      (out_valid_o && out_item_o.fifo_count == '0 && !out_item_o.read_valid))
    else $error("flush did not empty the FIFO");

endmodule

bind uart_receiver_with_fifo urxf_checker u_checker (.*);
